### rtl/swb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swb_pkg: shared types for the separable weighted blur
// Command codes, transfer payloads, configuration indexes and controller
// states.
// ----------------------------------------------------------------------------
package swb_pkg;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_WR_PIXEL = 2'd0,
    CMD_WR_WEIGHT = 2'd1,
    CMD_FILT_ROW = 2'd2,
    CMD_FILT_COL = 2'd3
  } cmd_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_IMAGE_WIDTH = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_FILTER_RADIUS = 2'd2;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth = 9;

  // Input transfer payload
  typedef struct packed {
    cmd_e        command;
    logic [7:0]  column;
    logic [7:0]  row;
    logic [5:0]  weight_index;
    logic [15:0] weight_value;
    logic [7:0]  in_red;
    logic [7:0]  in_green;
    logic [7:0]  in_blue;
  } in_item_t;

  // Result transfer payload
  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       zero_weight_error;
  } out_item_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_EXEC,
    ST_SCAN,
    ST_DRAIN,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

### rtl/separable_weighted_blur.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// separable_weighted_blur: one-axis weighted blur over a stored RGB frame
// Holds the frame and a symmetric weight table in on-chip memories. Writes
// load pixels and weights; a filter command sums weighted neighbours along a
// row or a column and divides by the sum of the weights used.
//
//   channel   direction  handshake                   payload
//   in        input      in_valid_i / in_stall_o     in_data_i  (in_item_t)
//   out       output     out_valid_o / out_stall_i   out_data_o (out_item_t)
//   cfg       input      cfg_we_i                    cfg_index_i, cfg_wdata_i
//
// Pixel and weight writes pass through the address and execute states. A
// filter scans offset distances 0 to radius R, reading both sides of the
// centre in the same cycle through the two frame read ports, then runs an
// 8-bit restoring divide. One item is worked on at a time.
// The result sits in an output register, so the next item is taken while a
// result is still stalled. Reset clears control state only; memory contents
// are undefined until written.
// ----------------------------------------------------------------------------
module separable_weighted_blur import swb_pkg::*; #(
  parameter int unsigned MAX_WIDTH        = 256,
  parameter int unsigned MAX_HEIGHT       = 256,
  parameter int unsigned MAX_RADIUS       = 63,
  parameter int unsigned MAX_FRAME_PIXELS = 65536
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  in_item_t                 in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output out_item_t                out_data_o,
  input  logic                     cfg_we_i,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_wdata_i
);

  localparam int unsigned AW   = (MAX_FRAME_PIXELS > 1) ? $clog2(MAX_FRAME_PIXELS) : 1;
  localparam int unsigned ADW  = (AW > 18) ? AW : 18;
  localparam int unsigned WIW  = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;
  localparam int unsigned CMPW = (WIW > 9) ? WIW : 9;
  localparam longint unsigned NMax = (64'(MAX_RADIUS) * 64'd2 + 64'd1) * 64'd65535;
  localparam longint unsigned CMax = NMax * 64'd255;
  localparam int unsigned NW   = $clog2(NMax + 64'd1);
  localparam int unsigned SW   = $clog2(CMax + 64'd1);
  localparam int unsigned DW   = (SW > NW + 8) ? SW : NW + 8;

  // Configuration registers
  logic [8:0] image_width_q, image_height_q;
  logic [5:0] filter_radius_q;

  // Controller
  state_e state_q, state_d;
  logic   out_load;

  // Item and scan registers
  in_item_t         item_q;
  logic             in_image_q;
  logic [ADW-1:0]   center_q, lo_addr_q, hi_addr_q, stride_q;
  logic [7:0]       pos_q;
  logic [8:0]       hroom_q;
  logic [WIW-1:0]   d_q;
  logic [2:0]       dstep_q;

  // Read stage
  logic [23:0]      lo_pix_q, hi_pix_q;
  logic [15:0]      wt_rd_q;
  logic             s_valid_q, s_lo_use_q, s_hi_use_q;
  logic [1:0]       s_cnt_q;

  // Accumulators, also the divide remainders
  logic [SW-1:0]    acc_q [3];
  logic [NW-1:0]    n_q;
  logic [7:0]       quo_q [3];

  // Output register
  logic             out_valid_q;
  out_item_t        out_data_q;

  // Memories
  logic [23:0]      frame_mem [MAX_FRAME_PIXELS];
  logic [15:0]      wt_mem [MAX_RADIUS + 1];

  // Effective dimensions and radius
  logic [8:0]       w_eff, h_eff;
  logic [WIW-1:0]   r_eff;

  always_comb begin
    if (image_width_q == 9'd0) begin
      w_eff = 9'd1;
    end else if (32'(image_width_q) > MAX_WIDTH) begin
      w_eff = 9'(MAX_WIDTH);
    end else begin
      w_eff = image_width_q;
    end
    if (image_height_q == 9'd0) begin
      h_eff = 9'd1;
    end else if (32'(image_height_q) > MAX_HEIGHT) begin
      h_eff = 9'(MAX_HEIGHT);
    end else begin
      h_eff = image_height_q;
    end
    if (32'(filter_radius_q) > MAX_RADIUS) begin
      r_eff = WIW'(MAX_RADIUS);
    end else begin
      r_eff = WIW'(filter_radius_q);
    end
  end

  // Side checks for the current scan step
  logic lo_ok, hi_ok, lo_mem_ok, hi_mem_ok, along_row;

  assign along_row = (item_q.command == CMD_FILT_ROW);
  assign lo_ok     = CMPW'(d_q) <= CMPW'(pos_q);
  assign hi_ok     = (d_q != '0) && (CMPW'(d_q) <= CMPW'(hroom_q));
  assign lo_mem_ok = 64'(lo_addr_q) < 64'(MAX_FRAME_PIXELS);
  assign hi_mem_ok = 64'(hi_addr_q) < 64'(MAX_FRAME_PIXELS);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q   <= 9'd256;
      image_height_q  <= 9'd256;
      filter_radius_q <= 6'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH:   image_width_q   <= cfg_wdata_i;
        CFG_IMAGE_HEIGHT:  image_height_q  <= cfg_wdata_i;
        CFG_FILTER_RADIUS: filter_radius_q <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and handshake
  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) state_d = ST_ADDR;
      end
      ST_ADDR: state_d = ST_EXEC;
      ST_EXEC: begin
        if ((item_q.command == CMD_FILT_ROW || item_q.command == CMD_FILT_COL)
            && in_image_q) begin
          state_d = ST_SCAN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (d_q == r_eff) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_DIV;
      ST_DIV: begin
        if (n_q == '0 || dstep_q == 3'd0) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) item_q <= in_data_i;
      end
      ST_ADDR: begin
        center_q   <= ADW'(item_q.row) * ADW'(w_eff) + ADW'(item_q.column);
        in_image_q <= ({1'b0, item_q.column} < w_eff) && ({1'b0, item_q.row} < h_eff);
      end
      ST_EXEC: begin
        lo_addr_q <= center_q;
        hi_addr_q <= center_q;
        stride_q  <= along_row ? ADW'(1) : ADW'(w_eff);
        pos_q     <= along_row ? item_q.column : item_q.row;
        hroom_q   <= along_row ? (w_eff - {1'b0, item_q.column} - 9'd1)
                               : (h_eff - {1'b0, item_q.row} - 9'd1);
        d_q       <= '0;
        dstep_q   <= 3'd7;
        n_q       <= '0;
        for (int c = 0; c < 3; c++) acc_q[c] <= '0;
      end
      ST_SCAN: begin
        lo_addr_q <= lo_addr_q - stride_q;
        hi_addr_q <= hi_addr_q + stride_q;
        d_q       <= d_q + WIW'(1);
      end
      ST_DIV: begin
        dstep_q <= dstep_q - 3'd1;
      end
      default: ;
    endcase

    // Multiply-accumulate on the data read in the previous cycle
    if (s_valid_q) begin
      for (int c = 0; c < 3; c++) begin
        acc_q[c] <= acc_q[c] + SW'(wt_rd_q) * SW'(
                      {1'b0, s_lo_use_q ? lo_pix_q[8*c +: 8] : 8'd0} +
                      {1'b0, s_hi_use_q ? hi_pix_q[8*c +: 8] : 8'd0});
      end
      unique case (s_cnt_q)
        2'd2:    n_q <= n_q + NW'({wt_rd_q, 1'b0});
        2'd1:    n_q <= n_q + NW'(wt_rd_q);
        default: ;
      endcase
    end

    // Restoring divide, one quotient bit per cycle, all channels in parallel
    if (state_q == ST_DIV) begin
      for (int c = 0; c < 3; c++) begin
        if (DW'(acc_q[c]) >= (DW'(n_q) << dstep_q)) begin
          acc_q[c] <= SW'(DW'(acc_q[c]) - (DW'(n_q) << dstep_q));
          quo_q[c] <= {quo_q[c][6:0], 1'b1};
        end else begin
          quo_q[c] <= {quo_q[c][6:0], 1'b0};
        end
      end
    end
  end

  // Read stage control; scan and accumulate never overlap a memory write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else begin
      s_valid_q <= (state_q == ST_SCAN);
    end
  end

  always_ff @(posedge clk_i) begin
    s_lo_use_q <= lo_ok && lo_mem_ok;
    s_hi_use_q <= hi_ok && hi_mem_ok;
    s_cnt_q    <= {1'b0, lo_ok} + {1'b0, hi_ok};
  end

  // Frame memory: one write port, two read ports
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC && item_q.command == CMD_WR_PIXEL && in_image_q &&
        64'(center_q) < 64'(MAX_FRAME_PIXELS)) begin
      frame_mem[center_q[AW-1:0]] <= {item_q.in_red, item_q.in_green, item_q.in_blue};
    end
    lo_pix_q <= frame_mem[lo_addr_q[AW-1:0]];
    hi_pix_q <= frame_mem[hi_addr_q[AW-1:0]];
  end

  // Weight memory
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC && item_q.command == CMD_WR_WEIGHT &&
        32'(item_q.weight_index) <= MAX_RADIUS) begin
      wt_mem[WIW'(item_q.weight_index)] <= item_q.weight_value;
    end
    wt_rd_q <= wt_mem[d_q];
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (n_q == '0) begin
        out_data_q <= '{out_red: 8'd0, out_green: 8'd0, out_blue: 8'd0,
                        zero_weight_error: 1'b1};
      end else begin
        out_data_q <= '{out_red: quo_q[2], out_green: quo_q[1], out_blue: quo_q[0],
                        zero_weight_error: 1'b0};
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### rtl/swb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swb_checker: port-level checks for the separable weighted blur
// Watches the transfer channels of the top level over time.
// ----------------------------------------------------------------------------
module swb_checker import swb_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // An error result carries zero channels
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_weight_error |->
      out_data_o.out_red == 8'd0 && out_data_o.out_green == 8'd0 &&
      out_data_o.out_blue == 8'd0)
    else $error("zero weight error with nonzero channels");

  // One item at a time: input is held off right after a transfer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while busy");

  // A new result only comes out of a busy period
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without work in progress");

endmodule

bind separable_weighted_blur swb_checker u_swb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
